[rtl/core/cbte_pkg.sv]
package cbte_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int RATIO_BITS_DEF  = 16;
    localparam int TIME_WIDTH_DEF  = 32;

    localparam int TOTAL_WIDTH = 32;
    localparam int DELTA_WIDTH = 16;
    localparam int CFG_IDX_W   = 3;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_ONE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_TWO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVAL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_TIME  = 3'd4;

    // multiplier schedule: six basis products, then four terms per axis
    localparam int BASIS_OPS = 6;
    localparam int MUL_OPS   = BASIS_OPS + 12;

    localparam logic [1:0] TERM_FIRST = 2'd0;
    localparam logic [1:0] TERM_LAST  = 2'd3;
    localparam logic [1:0] AXIS_X     = 2'd0;
    localparam logic [1:0] AXIS_Y     = 2'd1;
    localparam logic [1:0] AXIS_Z     = 2'd2;

    typedef enum logic [2:0] {
        OP_U2,
        OP_T2,
        OP_B0,
        OP_B1,
        OP_B2,
        OP_B3,
        OP_MAC
    } t_op;

    typedef struct packed {
        logic       accept;
        logic       div_init;
        logic       div_step;
        logic       mul_issue;
        t_op        op;
        logic [1:0] axis;
        logic [1:0] term;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic reached;
    } t_stat;

endpackage

[rtl/core/cbte_step_if.sv]
interface cbte_step_if;
    logic                              valid;
    logic                              ready;
    logic [cbte_pkg::DELTA_WIDTH-1:0] time_delta;

    modport source (output valid, output time_delta, input ready);
    modport sink (input valid, input time_delta, output ready);
endinterface

[rtl/core/cbte_point_if.sv]
interface cbte_point_if #(
    parameter int COORD_WIDTH = cbte_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic                          done_res;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output done_res, input ready);
    modport sink (input valid, input pos_x, input pos_y, input pos_z,
                  input done_res, output ready);
endinterface

[rtl/core/cbte_ctrl.sv]
module cbte_ctrl #(
    parameter int RATIO_BITS = cbte_pkg::RATIO_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  cbte_pkg::t_stat i_stat,
    output cbte_pkg::t_cmd  o_cmd
);

    localparam int CNT_MAX = (RATIO_BITS > cbte_pkg::MUL_OPS) ? RATIO_BITS
                                                              : cbte_pkg::MUL_OPS;
    localparam int CNT_W   = $clog2(CNT_MAX);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_MUL,
        S_DRAIN,
        S_FIN
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_valid;
    logic [CNT_W-1:0]   mac_idx;
    logic               out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;
    assign mac_idx     = r_cnt - CNT_W'(cbte_pkg::BASIS_OPS);

    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = cbte_pkg::OP_MAC;
        o_cmd.accept    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.div_init  = (r_state == S_CHECK) && !i_stat.reached;
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.mul_issue = (r_state == S_MUL);
        o_cmd.out_load  = (r_state == S_FIN) && out_free;
        if (r_cnt < CNT_W'(cbte_pkg::BASIS_OPS)) begin
            o_cmd.op = cbte_pkg::t_op'(r_cnt[2:0]);
        end
        o_cmd.axis = mac_idx[3:2];
        o_cmd.term = mac_idx[1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_cnt   <= '0;
                    r_state <= i_stat.reached ? S_FIN : S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(RATIO_BITS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_MUL: begin
                    if (r_cnt == CNT_W'(cbte_pkg::MUL_OPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/cbte_datapath.sv]
module cbte_datapath #(
    parameter int COORD_WIDTH = cbte_pkg::COORD_WIDTH_DEF,
    parameter int RATIO_BITS  = cbte_pkg::RATIO_BITS_DEF,
    parameter int TIME_WIDTH  = cbte_pkg::TIME_WIDTH_DEF,
    parameter int CFG_WIDTH   = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cbte_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_WIDTH-1:0]                i_cfg_data,
    input  logic [cbte_pkg::DELTA_WIDTH-1:0]    i_time_delta,
    input  cbte_pkg::t_cmd                      i_cmd,
    output cbte_pkg::t_stat                     o_stat,
    output logic signed [COORD_WIDTH-1:0]       o_pos_x,
    output logic signed [COORD_WIDTH-1:0]       o_pos_y,
    output logic signed [COORD_WIDTH-1:0]       o_pos_z,
    output logic                                o_done
);

    localparam int C     = COORD_WIDTH;
    localparam int R     = RATIO_BITS;
    localparam int TOT_W = cbte_pkg::TOTAL_WIDTH;
    localparam int CMP_W = (TIME_WIDTH > TOT_W) ? TIME_WIDTH : TOT_W;
    localparam int PT_W  = 3 * C;
    localparam int MA_W  = R + 3;
    localparam int MB_W  = ((R + 1 > C) ? R + 1 : C) + 1;
    localparam int P_W   = MA_W + MB_W;

    // configuration and time state
    logic [PT_W-1:0]        r_pt [4];
    logic [TOT_W-1:0]       r_total;
    logic [TIME_WIDTH-1:0]  r_elapsed;

    // divider
    logic [TOT_W-1:0]       r_rem;
    logic [R-1:0]           r_t;

    // basis values, Q.R
    logic [R:0]             r_u2;
    logic [R:0]             r_t2;
    logic [R:0]             r_b [4];

    // shared multiplier and writeback tag
    logic signed [P_W-1:0]  r_prod;
    logic                   r_wb_valid;
    cbte_pkg::t_op          r_wb_op;
    logic [1:0]             r_wb_axis;
    logic [1:0]             r_wb_term;
    logic signed [P_W-1:0]  r_acc;
    logic signed [C-1:0]    r_pos_x;
    logic signed [C-1:0]    r_pos_y;
    logic signed [C-1:0]    r_pos_z;

    logic [TIME_WIDTH:0]    elapsed_sum;
    logic [TOT_W:0]         rem_sh;
    logic                   rem_ge;
    logic [R:0]             u_val;
    logic [R+1:0]           t_x3;
    logic [R+1:0]           t2_x3;
    logic [C-1:0]           coord;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [P_W-1:0]  prod_sh;
    logic [R:0]             basis_res;
    logic signed [P_W-1:0]  acc_sum;
    logic signed [P_W-1:0]  acc_sh;
    logic signed [C-1:0]    pos_sat;

    assign o_stat.reached = CMP_W'(r_elapsed) >= CMP_W'(r_total);

    assign elapsed_sum = {1'b0, r_elapsed} + (TIME_WIDTH + 1)'(i_time_delta);
    assign rem_sh      = {r_rem, 1'b0};
    assign rem_ge      = rem_sh >= {1'b0, r_total};

    assign u_val = {1'b1, {R{1'b0}}} - {1'b0, r_t};
    assign t_x3  = (R + 2)'(r_t) + ((R + 2)'(r_t) << 1);
    assign t2_x3 = (R + 2)'(r_t2) + ((R + 2)'(r_t2) << 1);
    assign coord = r_pt[i_cmd.term][i_cmd.axis * C +: C];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            cbte_pkg::OP_U2: begin
                mul_a = MA_W'(u_val);
                mul_b = MB_W'(u_val);
            end
            cbte_pkg::OP_T2: begin
                mul_a = MA_W'(r_t);
                mul_b = MB_W'(r_t);
            end
            cbte_pkg::OP_B0: begin
                mul_a = MA_W'(r_u2);
                mul_b = MB_W'(u_val);
            end
            cbte_pkg::OP_B1: begin
                mul_a = MA_W'(t_x3);
                mul_b = MB_W'(r_u2);
            end
            cbte_pkg::OP_B2: begin
                mul_a = MA_W'(t2_x3);
                mul_b = MB_W'(u_val);
            end
            cbte_pkg::OP_B3: begin
                mul_a = MA_W'(r_t2);
                mul_b = MB_W'(r_t);
            end
            cbte_pkg::OP_MAC: begin
                mul_a = MA_W'(r_b[i_cmd.term]);
                mul_b = MB_W'($signed(coord));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_sh   = r_prod >>> R;
    assign basis_res = prod_sh[R:0];
    assign acc_sum   = ((r_wb_term == cbte_pkg::TERM_FIRST) ? '0 : r_acc) + r_prod;
    assign acc_sh    = acc_sum >>> R;

    // arithmetic shift floors; then saturate to the coordinate range
    always_comb begin
        if (!acc_sh[P_W-1] && (|acc_sh[P_W-2:C-1])) begin
            pos_sat = {1'b0, {(C-1){1'b1}}};
        end else if (acc_sh[P_W-1] && !(&acc_sh[P_W-2:C-1])) begin
            pos_sat = {1'b1, {(C-1){1'b0}}};
        end else begin
            pos_sat = acc_sh[C-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt[0]    <= '0;
            r_pt[1]    <= '0;
            r_pt[2]    <= '0;
            r_pt[3]    <= '0;
            r_total    <= TOT_W'(1);
            r_elapsed  <= '0;
            r_wb_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cbte_pkg::REG_ORIGIN,
                    cbte_pkg::REG_CONTROL_ONE,
                    cbte_pkg::REG_CONTROL_TWO,
                    cbte_pkg::REG_ARRIVAL: begin
                        r_pt[i_cfg_idx[1:0]] <= i_cfg_data[PT_W-1:0];
                    end
                    cbte_pkg::REG_TOTAL_TIME: begin
                        r_total <= i_cfg_data[TOT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.accept) begin
                r_elapsed <= elapsed_sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}}
                                                     : elapsed_sum[TIME_WIDTH-1:0];
            end
            r_wb_valid <= i_cmd.mul_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        // restoring divide, one quotient bit per cycle; elapsed < total here
        if (i_cmd.div_init) begin
            r_rem <= TOT_W'(r_elapsed);
            r_t   <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? TOT_W'(rem_sh - {1'b0, r_total}) : rem_sh[TOT_W-1:0];
            r_t   <= {r_t[R-2:0], rem_ge};
        end

        if (i_cmd.mul_issue) begin
            r_prod    <= mul_a * mul_b;
            r_wb_op   <= i_cmd.op;
            r_wb_axis <= i_cmd.axis;
            r_wb_term <= i_cmd.term;
        end

        if (r_wb_valid) begin
            case (r_wb_op)
                cbte_pkg::OP_U2: r_u2    <= basis_res;
                cbte_pkg::OP_T2: r_t2    <= basis_res;
                cbte_pkg::OP_B0: r_b[0]  <= basis_res;
                cbte_pkg::OP_B1: r_b[1]  <= basis_res;
                cbte_pkg::OP_B2: r_b[2]  <= basis_res;
                cbte_pkg::OP_B3: r_b[3]  <= basis_res;
                cbte_pkg::OP_MAC: begin
                    r_acc <= acc_sum;
                    if (r_wb_term == cbte_pkg::TERM_LAST) begin
                        case (r_wb_axis)
                            cbte_pkg::AXIS_X: r_pos_x <= pos_sat;
                            cbte_pkg::AXIS_Y: r_pos_y <= pos_sat;
                            cbte_pkg::AXIS_Z: r_pos_z <= pos_sat;
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.out_load) begin
            if (o_stat.reached) begin
                o_pos_x <= r_pt[3][C-1:0];
                o_pos_y <= r_pt[3][2*C-1:C];
                o_pos_z <= r_pt[3][3*C-1:2*C];
                o_done  <= 1'b1;
            end else begin
                o_pos_x <= r_pos_x;
                o_pos_y <= r_pos_y;
                o_pos_z <= r_pos_z;
                o_done  <= 1'b0;
            end
        end
    end

endmodule

[rtl/core/cubic_bezier_timed_evaluator.sv]
// Channel  | Dir | Payload                          | Transfer
// ---------+-----+----------------------------------+--------------------------
// i_step   | in  | time_delta                       | valid & ready at clk edge
// o_point  | out | pos_x, pos_y, pos_z, done_res    | valid & ready at clk edge
// cfg      | in  | i_cfg_idx, i_cfg_data            | i_cfg_we at clk edge
//
// Each step divides elapsed time by total time for the ratio, then evaluates the curve:
// the restoring divider yields one ratio bit a cycle, then one shared multiplier
// runs 18 products back to back. A step that reaches the end time skips both stages.
// Synchronous active-low reset clears elapsed time and loads the register defaults.
// Results sit in an output register; a stalled output holds only the finish step.
module cubic_bezier_timed_evaluator #(
    parameter int COORD_WIDTH = cbte_pkg::COORD_WIDTH_DEF,
    parameter int RATIO_BITS  = cbte_pkg::RATIO_BITS_DEF,
    parameter int TIME_WIDTH  = cbte_pkg::TIME_WIDTH_DEF,
    parameter int CFG_WIDTH   = (3 * COORD_WIDTH > cbte_pkg::TOTAL_WIDTH)
                                ? 3 * COORD_WIDTH : cbte_pkg::TOTAL_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cbte_step_if.sink                       i_step,
    cbte_point_if.source                    o_point,
    input  logic                            i_cfg_we,
    input  logic [cbte_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_WIDTH-1:0]            i_cfg_data
);

    cbte_pkg::t_cmd  cmd;
    cbte_pkg::t_stat stat;

    cbte_ctrl #(
        .RATIO_BITS (RATIO_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_step.valid),
        .o_in_ready  (i_step.ready),
        .o_out_valid (o_point.valid),
        .i_out_ready (o_point.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    cbte_datapath #(
        .COORD_WIDTH (COORD_WIDTH),
        .RATIO_BITS  (RATIO_BITS),
        .TIME_WIDTH  (TIME_WIDTH),
        .CFG_WIDTH   (CFG_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_time_delta (i_step.time_delta),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_pos_x      (o_point.pos_x),
        .o_pos_y      (o_point.pos_y),
        .o_pos_z      (o_point.pos_z),
        .o_done       (o_point.done_res)
    );

endmodule
